>>> rtl/core/urpd_pkg.sv
`timescale 1ns / 1ps

package urpd_pkg;

   // widths of the configuration registers
   localparam int POLL_W    = 24;
   localparam int TRIG_W    = 8;
   localparam int TIMEOUT_W = 16;
   localparam int DIST_W    = 16;
   localparam int NEEDED_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // default timer width for phase timing
   localparam int TIMER_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POLL_PERIOD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_THRESH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_THRESH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_READINGS      = 3'd5;

   // reset values
   localparam logic [POLL_W-1:0]    POLL_RST      = 24'd100000;
   localparam logic [TRIG_W-1:0]    TRIG_RST      = 8'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd25000;
   localparam logic [DIST_W-1:0]    DETECT_RST    = 16'd165;
   localparam logic [DIST_W-1:0]    EXIT_RST      = 16'd220;
   localparam logic [NEEDED_W-1:0]  READINGS_RST  = 4'd3;

   // distance = ticks * 343 / 2000, kept as quotient and remainder
   localparam int REM_W = 11;
   localparam logic [REM_W:0] SOUND_NUM = 12'd343;
   localparam logic [REM_W:0] SOUND_DEN = 12'd2000;
   localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;
   localparam logic [POLL_W-1:0] PERIOD_MAX = 24'hFFFFFF;
   localparam logic [NEEDED_W-1:0] CLOSE_MAX = 4'd15;

   typedef struct packed {
      logic [POLL_W-1:0]    poll_period;
      logic [TRIG_W-1:0]    trigger_width;
      logic [TIMEOUT_W-1:0] echo_timeout;
      logic [DIST_W-1:0]    detect_thresh;
      logic [DIST_W-1:0]    exit_thresh;
      logic [NEEDED_W-1:0]  readings_needed;
   } cfg_type;

   // what the sequencer hands to the presence logic for one tick
   typedef struct packed {
      logic              trig;
      logic              fresh;
      logic [DIST_W-1:0] range_mm;
   } meas_type;

endpackage

>>> rtl/core/urpd_csr.sv
`timescale 1ns / 1ps

module urpd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [urpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [urpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output urpd_pkg::cfg_type                 cfg
);
   import urpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_POLL_PERIOD:   cfg_in.poll_period     = csr_wdata[POLL_W-1:0];
            REG_TRIGGER_WIDTH: cfg_in.trigger_width   = csr_wdata[TRIG_W-1:0];
            REG_ECHO_TIMEOUT:  cfg_in.echo_timeout    = csr_wdata[TIMEOUT_W-1:0];
            REG_DETECT_THRESH: cfg_in.detect_thresh   = csr_wdata[DIST_W-1:0];
            REG_EXIT_THRESH:   cfg_in.exit_thresh     = csr_wdata[DIST_W-1:0];
            REG_READINGS:      cfg_in.readings_needed = csr_wdata[NEEDED_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_period     <= POLL_RST;
         cfg_ff.trigger_width   <= TRIG_RST;
         cfg_ff.echo_timeout    <= TIMEOUT_RST;
         cfg_ff.detect_thresh   <= DETECT_RST;
         cfg_ff.exit_thresh     <= EXIT_RST;
         cfg_ff.readings_needed <= READINGS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/urpd_sequencer.sv
`timescale 1ns / 1ps

module urpd_sequencer #(
   parameter int TIMER_BITS = urpd_pkg::TIMER_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                echo,
   input  urpd_pkg::cfg_type   cfg,
   output urpd_pkg::meas_type  meas
);
   import urpd_pkg::*;

   localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_READ} phase_type;

   phase_type             phase_ff, phase_in;
   logic [POLL_W-1:0]     period_ff, period_in, period_inc;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in, elapsed_tick;
   logic                  ticked;
   logic [DIST_W-1:0]     quo_ff, quo_in, quo_tick;
   logic [REM_W-1:0]      rem_ff, rem_in, rem_tick;
   logic [REM_W:0]        rem_sum;
   logic                  carry;
   logic                  timeout;

   always_comb begin
      period_inc   = (period_ff != PERIOD_MAX) ? period_ff + 1'b1 : period_ff;
      ticked       = (elapsed_ff != TIMER_MAX);
      elapsed_tick = ticked ? elapsed_ff + 1'b1 : elapsed_ff;
      timeout      = (CMP_W'(elapsed_tick) > CMP_W'(cfg.echo_timeout))
                     || (elapsed_tick == TIMER_MAX);

      // running quotient and remainder of ticks * 343 / 2000
      rem_sum  = {1'b0, rem_ff} + SOUND_NUM;
      carry    = (rem_sum >= SOUND_DEN);
      rem_tick = rem_ff;
      quo_tick = quo_ff;
      if (ticked) begin
         rem_tick = carry ? REM_W'(rem_sum - SOUND_DEN) : rem_sum[REM_W-1:0];
         if (carry && (quo_ff != DIST_MAX)) begin
            quo_tick = quo_ff + 1'b1;
         end
      end

      phase_in      = phase_ff;
      period_in     = period_inc;
      elapsed_in    = elapsed_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      meas.trig     = 1'b0;
      meas.fresh    = 1'b0;
      meas.range_mm = quo_tick;

      case (phase_ff)
         PH_IDLE: begin
            if (period_inc >= cfg.poll_period) begin
               period_in = '0;
               phase_in  = PH_TRIG;
            end
         end
         PH_TRIG: begin
            meas.trig  = 1'b1;
            elapsed_in = '0;
            phase_in   = PH_WAIT;
         end
         PH_WAIT: begin
            elapsed_in = elapsed_tick;
            if (elapsed_tick < TIMER_BITS'(cfg.trigger_width)) begin
               meas.trig = 1'b1;
            end else if (echo) begin
               elapsed_in = '0;
               quo_in     = '0;
               rem_in     = '0;
               phase_in   = PH_READ;
            end else if (timeout) begin
               phase_in = PH_IDLE;
            end
         end
         PH_READ: begin
            elapsed_in = elapsed_tick;
            quo_in     = quo_tick;
            rem_in     = rem_tick;
            if (!echo) begin
               meas.fresh = 1'b1;
               phase_in   = PH_IDLE;
            end else if (timeout) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         period_ff  <= '0;
         elapsed_ff <= '0;
         quo_ff     <= '0;
         rem_ff     <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         period_ff  <= period_in;
         elapsed_ff <= elapsed_in;
         quo_ff     <= quo_in;
         rem_ff     <= rem_in;
      end
   end

endmodule

>>> rtl/core/urpd_presence.sv
`timescale 1ns / 1ps

module urpd_presence (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  urpd_pkg::meas_type                meas,
   input  urpd_pkg::cfg_type                 cfg,
   output logic [urpd_pkg::DIST_W-1:0]       distance,
   output logic                              present,
   output logic                              event_start
);
   import urpd_pkg::*;

   logic [DIST_W-1:0]   last_ff, last_in;
   logic                det_ff, det_in;
   logic [NEEDED_W-1:0] close_ff, close_in, close_sat;

   always_comb begin
      last_in     = last_ff;
      det_in      = det_ff;
      close_in    = close_ff;
      event_start = 1'b0;
      close_sat   = (close_ff != CLOSE_MAX) ? close_ff + 1'b1 : close_ff;
      if (meas.fresh) begin
         last_in = meas.range_mm;
         if (!det_ff) begin
            if (meas.range_mm < cfg.detect_thresh) begin
               close_in = close_sat;
               if (close_sat >= cfg.readings_needed) begin
                  det_in      = 1'b1;
                  event_start = 1'b1;
               end
            end else begin
               close_in = '0;
            end
         end else if (meas.range_mm > cfg.exit_thresh) begin
            det_in   = 1'b0;
            close_in = '0;
         end
      end
      distance = last_in;
      present  = det_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= DIST_MAX;
         det_ff   <= 1'b0;
         close_ff <= '0;
      end else if (step_en) begin
         last_ff  <= last_in;
         det_ff   <= det_in;
         close_ff <= close_in;
      end
   end

endmodule

>>> rtl/core/ultrasonic_range_presence_detector_core.sv
`timescale 1ns / 1ps

// channel  direction  transfer when          payload
// req      in         req_valid & !req_stall req_echo_level
// rsp      out        rsp_valid & !rsp_stall rsp_trigger_level, rsp_range_mm,
//                                            rsp_distance_new, rsp_object_present,
//                                            rsp_detect_event
// csr      in         csr_write_en           csr_index, csr_wdata
//
// one result transaction per request transaction; rsp_valid rises once the accepted request
// has passed the tick register and then the result register; one request per cycle sustained
// while rsp_stall is low, through a single pass of sequencer and presence logic
// reset is synchronous and active high; it restores register defaults and the idle phase
// req_stall rises only when both the tick register and the result register are full
// and the result is stalled
module ultrasonic_range_presence_detector_core #(
   parameter int TIMER_BITS = urpd_pkg::TIMER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: one microsecond tick
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_echo_level,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_trigger_level,
   output logic [urpd_pkg::DIST_W-1:0]       rsp_range_mm,
   output logic                              rsp_distance_new,
   output logic                              rsp_object_present,
   output logic                              rsp_detect_event,
   // configuration writes
   input  logic                              csr_write_en,
   input  logic [urpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [urpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import urpd_pkg::*;

   cfg_type           cfg;
   meas_type          meas;

   // tick register
   logic              in_vld_ff;
   logic              in_echo_ff;

   // result register
   logic              out_vld_ff;
   logic              out_trig_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic              out_new_ff;
   logic              out_present_ff;
   logic              out_event_ff;

   logic              step_en;
   logic [DIST_W-1:0] distance_c;
   logic              present_c;
   logic              event_c;

   // a tick is processed when the result register is empty or being drained
   assign step_en   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !step_en;

   urpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // phase sequencing, timers and distance conversion
   urpd_sequencer #(
      .TIMER_BITS (TIMER_BITS)
   ) u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .echo    (in_echo_ff),
      .cfg     (cfg),
      .meas    (meas)
   );

   // last distance and presence hysteresis
   urpd_presence u_presence (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .meas        (meas),
      .cfg         (cfg),
      .distance    (distance_c),
      .present     (present_c),
      .event_start (event_c)
   );

   // tick register loads whenever it is not holding a stalled tick
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_echo_ff <= req_echo_level;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (step_en) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_trig_ff    <= meas.trig;
         out_dist_ff    <= distance_c;
         out_new_ff     <= meas.fresh;
         out_present_ff <= present_c;
         out_event_ff   <= event_c;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_trigger_level  = out_trig_ff;
   assign rsp_range_mm       = out_dist_ff;
   assign rsp_distance_new   = out_new_ff;
   assign rsp_object_present = out_present_ff;
   assign rsp_detect_event   = out_event_ff;

   // a detection episode starts only on a completed reading and leaves presence set
   a_event_fresh : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_detect_event |-> rsp_object_present && rsp_distance_new)
      else $error("detect event without a new reading or presence");

   // a reading completes in the read phase, never while the trigger is driven
   a_new_no_trig : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance_new |-> !rsp_trigger_level)
      else $error("reading completed while trigger high");

   // back pressure only when both stages hold a transaction
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("request stalled with a free stage");

   // a processed tick always shows up in the result register
   a_step_loads : assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_vld_ff)
      else $error("processed tick lost");

endmodule
